// ===== rtl/core/ghea_pkg.sv =====
// ----------------------------------------------------------------------------
// Guest/host energy accountant package
// Shared constants, opcode and phase codes, and the transaction types used
// between the input stage, the ledger and the output stage.
// ----------------------------------------------------------------------------
package ghea_pkg;

   localparam int NUM_COUNTERS = 4;
   localparam int CTR_SLOTS    = 4;
   localparam int CTR_W        = 64;
   localparam int OP_W         = 2;

   typedef enum logic [OP_W-1:0] {
      OP_GUEST_ENTRY = 2'd0,
      OP_GUEST_EXIT  = 2'd1,
      OP_START       = 2'd2,
      OP_END         = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      PHASE_FIRST       = 2'd0,
      PHASE_AWAIT_EXIT  = 2'd1,
      PHASE_AWAIT_ENTRY = 2'd2
   } phase_type;

   typedef logic [CTR_SLOTS-1:0][CTR_W-1:0] ctr_vec_type;

   typedef struct packed {
      op_type      op;
      ctr_vec_type readings;
   } req_type;

   typedef struct packed {
      ctr_vec_type guest;
      ctr_vec_type host;
      logic        phase_error;
   } rsp_type;

endpackage

// ===== rtl/core/ghea_if.sv =====
// ----------------------------------------------------------------------------
// Guest/host energy accountant channel interfaces
// Valid/ready channels for event transactions and for result transactions.
// ----------------------------------------------------------------------------
interface ghea_req_if;
   logic                     valid;
   logic                     ready;
   logic [ghea_pkg::OP_W-1:0]  op;
   logic [ghea_pkg::CTR_W-1:0] pkg_reading;
   logic [ghea_pkg::CTR_W-1:0] core_reading;
   logic [ghea_pkg::CTR_W-1:0] uncore_reading;
   logic [ghea_pkg::CTR_W-1:0] dram_reading;

   modport source (output valid, output op, output pkg_reading, output core_reading,
                   output uncore_reading, output dram_reading, input ready);
   modport sink   (input valid, input op, input pkg_reading, input core_reading,
                   input uncore_reading, input dram_reading, output ready);
endinterface

interface ghea_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [ghea_pkg::CTR_W-1:0] guest_pkg;
   logic [ghea_pkg::CTR_W-1:0] guest_core;
   logic [ghea_pkg::CTR_W-1:0] guest_uncore;
   logic [ghea_pkg::CTR_W-1:0] guest_dram;
   logic [ghea_pkg::CTR_W-1:0] host_pkg;
   logic [ghea_pkg::CTR_W-1:0] host_core;
   logic [ghea_pkg::CTR_W-1:0] host_uncore;
   logic [ghea_pkg::CTR_W-1:0] host_dram;
   logic                       phase_error;

   modport source (output valid, output guest_pkg, output guest_core, output guest_uncore,
                   output guest_dram, output host_pkg, output host_core,
                   output host_uncore, output host_dram, output phase_error, input ready);
   modport sink   (input valid, input guest_pkg, input guest_core, input guest_uncore,
                   input guest_dram, input host_pkg, input host_core,
                   input host_uncore, input host_dram, input phase_error, output ready);
endinterface

// ===== rtl/core/ghea_req_stage.sv =====
// ----------------------------------------------------------------------------
// Event input register
// Captures one event transaction per cycle while the ledger keeps taking
// them, and holds each one until the ledger takes it.
// ----------------------------------------------------------------------------
module ghea_req_stage (
   input  logic              clock,
   input  logic              reset,
   ghea_req_if.sink          req_if,
   input  logic              take,
   output logic              valid,
   output ghea_pkg::req_type req
);

   logic              valid_ff;
   logic              valid_in;
   ghea_pkg::req_type req_ff;
   ghea_pkg::req_type req_in;
   logic              load;

   assign req_if.ready = !valid_ff || take;
   assign load         = req_if.valid && req_if.ready;

   always_comb begin
      valid_in = valid_ff;
      req_in   = req_ff;
      if (take) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in        = 1'b1;
         req_in.op       = ghea_pkg::op_type'(req_if.op);
         req_in.readings = {req_if.dram_reading, req_if.uncore_reading,
                            req_if.core_reading, req_if.pkg_reading};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      req_ff <= req_in;
   end

   assign valid = valid_ff;
   assign req   = req_ff;

endmodule

// ===== rtl/core/ghea_ledger.sv =====
// ----------------------------------------------------------------------------
// Energy ledger
// Holds the phase, the reading snapshots and the guest and host totals, and
// computes the state after one event.
// ----------------------------------------------------------------------------
module ghea_ledger (
   input  logic              clock,
   input  logic              reset,
   input  logic              enable,
   input  logic              fire,
   input  ghea_pkg::req_type req,
   output ghea_pkg::rsp_type rsp
);

   ghea_pkg::phase_type   phase_ff;
   ghea_pkg::phase_type   phase_in;
   ghea_pkg::ctr_vec_type last_ff;
   ghea_pkg::ctr_vec_type last_in;
   ghea_pkg::ctr_vec_type guest_ff;
   ghea_pkg::ctr_vec_type guest_in;
   ghea_pkg::ctr_vec_type host_ff;
   ghea_pkg::ctr_vec_type host_in;
   logic                  phase_error;

   // Phase sequencing.
   always_comb begin
      phase_in = phase_ff;
      if (enable) begin
         case (req.op)
            ghea_pkg::OP_GUEST_ENTRY: begin
               if (phase_ff != ghea_pkg::PHASE_AWAIT_EXIT) begin
                  phase_in = ghea_pkg::PHASE_AWAIT_EXIT;
               end
            end
            ghea_pkg::OP_GUEST_EXIT: begin
               if (phase_ff == ghea_pkg::PHASE_AWAIT_EXIT) begin
                  phase_in = ghea_pkg::PHASE_AWAIT_ENTRY;
               end
            end
            default: begin
               phase_in = ghea_pkg::PHASE_FIRST;
            end
         endcase
      end
   end

   // Snapshots, totals and the error flag.
   always_comb begin
      last_in     = last_ff;
      guest_in    = guest_ff;
      host_in     = host_ff;
      phase_error = 1'b0;
      if (enable) begin
         case (req.op)
            ghea_pkg::OP_GUEST_ENTRY: begin
               case (phase_ff)
                  ghea_pkg::PHASE_FIRST: begin
                     for (int i = 0; i < ghea_pkg::NUM_COUNTERS; i++) begin
                        last_in[i] = req.readings[i];
                     end
                  end
                  ghea_pkg::PHASE_AWAIT_EXIT: begin
                     phase_error = 1'b1;
                  end
                  default: begin
                     for (int i = 0; i < ghea_pkg::NUM_COUNTERS; i++) begin
                        host_in[i] = host_ff[i] + (req.readings[i] - last_ff[i]);
                        last_in[i] = req.readings[i];
                     end
                  end
               endcase
            end
            ghea_pkg::OP_GUEST_EXIT: begin
               if (phase_ff == ghea_pkg::PHASE_AWAIT_EXIT) begin
                  for (int i = 0; i < ghea_pkg::NUM_COUNTERS; i++) begin
                     guest_in[i] = guest_ff[i] + (req.readings[i] - last_ff[i]);
                     last_in[i]  = req.readings[i];
                  end
               end else begin
                  phase_error = 1'b1;
               end
            end
            ghea_pkg::OP_START: begin
               last_in  = '0;
               guest_in = '0;
               host_in  = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= ghea_pkg::PHASE_FIRST;
         last_ff  <= '0;
         guest_ff <= '0;
         host_ff  <= '0;
      end else if (fire) begin
         phase_ff <= phase_in;
         last_ff  <= last_in;
         guest_ff <= guest_in;
         host_ff  <= host_in;
      end
   end

   assign rsp.guest       = guest_in;
   assign rsp.host        = host_in;
   assign rsp.phase_error = phase_error;

endmodule

// ===== rtl/core/ghea_rsp_stage.sv =====
// ----------------------------------------------------------------------------
// Result output register
// Holds one result transaction until the receiver takes it, and accepts the
// next one in the same cycle.
// ----------------------------------------------------------------------------
module ghea_rsp_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  ghea_pkg::rsp_type rsp,
   output logic              can_take,
   ghea_rsp_if.source        rsp_if
);

   logic              valid_ff;
   logic              valid_in;
   ghea_pkg::rsp_type rsp_ff;

   assign can_take = !valid_ff || rsp_if.ready;

   always_comb begin
      valid_in = valid_ff;
      if (rsp_if.ready) begin
         valid_in = 1'b0;
      end
      if (fire) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (fire) begin
         rsp_ff <= rsp;
      end
   end

   assign rsp_if.valid        = valid_ff;
   assign rsp_if.guest_pkg    = rsp_ff.guest[0];
   assign rsp_if.guest_core   = rsp_ff.guest[1];
   assign rsp_if.guest_uncore = rsp_ff.guest[2];
   assign rsp_if.guest_dram   = rsp_ff.guest[3];
   assign rsp_if.host_pkg     = rsp_ff.host[0];
   assign rsp_if.host_core    = rsp_ff.host[1];
   assign rsp_if.host_uncore  = rsp_ff.host[2];
   assign rsp_if.host_dram    = rsp_ff.host[3];
   assign rsp_if.phase_error  = rsp_ff.phase_error;

endmodule

// ===== rtl/core/guest_host_energy_accountant.sv =====
// ----------------------------------------------------------------------------
// Guest/host energy accountant
// Splits four energy counters into guest and host totals from a stream of
// guest entry, guest exit, start and end events.
// ----------------------------------------------------------------------------
// Each event transaction on req_if carries an opcode and the current package,
// core, uncore and DRAM readings. For every event one result transaction on
// rsp_if returns all guest and host totals after the event and a phase error
// flag. The csr port writes the enable bit; with enable low every event still
// yields a result that shows the unchanged totals.
// An accepted event passes the input register and the combinational ledger
// into the output register, which drives rsp_if. Unless the receiver
// stalls, a new event is taken every cycle, set by the single ledger update
// per cycle. When the receiver stalls, the output register holds its result
// and the input register holds one more event; req_if.ready then falls.
// Reset clears the enable bit, the phase, the snapshots and all totals.
// ----------------------------------------------------------------------------
module guest_host_energy_accountant (
   input  logic       clock,
   input  logic       reset,
   ghea_req_if.sink   req_if,
   ghea_rsp_if.source rsp_if,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data
);

   logic              enable_ff;
   logic              enable_in;
   logic              s1_valid;
   ghea_pkg::req_type s1_req;
   ghea_pkg::rsp_type s1_rsp;
   logic              can_take;
   logic              fire;

   assign enable_in = csr_wr_en ? csr_wr_data : enable_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
      end else begin
         enable_ff <= enable_in;
      end
   end

   assign fire = s1_valid && can_take;

   ghea_req_stage u_req_stage (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .take   (fire),
      .valid  (s1_valid),
      .req    (s1_req)
   );

   ghea_ledger u_ledger (
      .clock  (clock),
      .reset  (reset),
      .enable (enable_ff),
      .fire   (fire),
      .req    (s1_req),
      .rsp    (s1_rsp)
   );

   ghea_rsp_stage u_rsp_stage (
      .clock    (clock),
      .reset    (reset),
      .fire     (fire),
      .rsp      (s1_rsp),
      .can_take (can_take),
      .rsp_if   (rsp_if)
   );

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Guest/host energy accountant testbench
// Drives entry, exit, start and end events with counter readings into the
// accountant, predicts the guest and host totals and the phase error flag of
// each result, and checks every result in order. Enable is toggled between
// phases while the block is idle, and both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
   import ghea_pkg::*;

   class energy_ledger;
      bit          enabled;
      phase_type   phase;
      ctr_vec_type last_seen;
      ctr_vec_type guest_sum;
      ctr_vec_type host_sum;
      rsp_type     expected_totals[$];
      int          errors;
      int          events_seen;
      int          ignored_events;
      int          results_seen;
      int          phase_errors;
      string       slot_name[CTR_SLOTS] = '{"pkg", "core", "uncore", "dram"};

      function new();
         enabled   = 1'b0;
         phase     = PHASE_FIRST;
         last_seen = '0;
         guest_sum = '0;
         host_sum  = '0;
      endfunction

      function void set_enable(bit value);
         enabled = value;
      endfunction

      function int pending();
         return expected_totals.size();
      endfunction

      function void fold_deltas(bit into_guest, ctr_vec_type now);
         int i;
         for (i = 0; i < NUM_COUNTERS && i < CTR_SLOTS; i++) begin
            if (into_guest) begin
               guest_sum[i] = guest_sum[i] + (now[i] - last_seen[i]);
            end else begin
               host_sum[i] = host_sum[i] + (now[i] - last_seen[i]);
            end
            last_seen[i] = now[i];
         end
      endfunction

      function void note_event(op_type op, ctr_vec_type now);
         rsp_type want;
         bit      err;
         int      i;
         err = 1'b0;
         events_seen++;
         if (!enabled) begin
            ignored_events++;
         end else begin
            case (op)
               OP_GUEST_ENTRY: begin
                  if (phase == PHASE_FIRST) begin
                     for (i = 0; i < NUM_COUNTERS && i < CTR_SLOTS; i++) begin
                        last_seen[i] = now[i];
                     end
                     phase = PHASE_AWAIT_EXIT;
                  end else if (phase == PHASE_AWAIT_EXIT) begin
                     err = 1'b1;
                  end else begin
                     fold_deltas(1'b0, now);
                     phase = PHASE_AWAIT_EXIT;
                  end
               end
               OP_GUEST_EXIT: begin
                  if (phase == PHASE_AWAIT_EXIT) begin
                     fold_deltas(1'b1, now);
                     phase = PHASE_AWAIT_ENTRY;
                  end else begin
                     err = 1'b1;
                  end
               end
               OP_START: begin
                  last_seen = '0;
                  guest_sum = '0;
                  host_sum  = '0;
                  phase     = PHASE_FIRST;
               end
               default: begin
                  phase = PHASE_FIRST;
               end
            endcase
         end
         if (err) phase_errors++;
         want.guest       = guest_sum;
         want.host        = host_sum;
         want.phase_error = err;
         expected_totals.push_back(want);
      endfunction

      function void check_field(string name, logic [CTR_W-1:0] want, logic [CTR_W-1:0] got);
         if (got !== want) begin
            $error("%s: expected %h, actual %h", name, want, got);
            errors++;
         end
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         int      i;
         if (expected_totals.size() == 0) begin
            $error("result transaction with no event waiting");
            errors++;
            return;
         end
         want = expected_totals.pop_front();
         results_seen++;
         for (i = 0; i < CTR_SLOTS; i++) begin
            check_field({"guest_", slot_name[i]}, want.guest[i], got.guest[i]);
            check_field({"host_", slot_name[i]}, want.host[i], got.host[i]);
         end
         check_field("phase_error", {63'd0, want.phase_error}, {63'd0, got.phase_error});
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset;
   logic         csr_wr_en;
   logic         csr_wr_data;
   energy_ledger ledger;
   ctr_vec_type  running;
   int unsigned  burst_left;

   ghea_req_if req_if ();
   ghea_rsp_if rsp_if ();

   guest_host_energy_accountant dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .rsp_if      (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_type got;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got.guest = {rsp_if.guest_dram, rsp_if.guest_uncore, rsp_if.guest_core,
                      rsp_if.guest_pkg};
         got.host = {rsp_if.host_dram, rsp_if.host_uncore, rsp_if.host_core,
                     rsp_if.host_pkg};
         got.phase_error = rsp_if.phase_error;
         ledger.check_result(got);
      end
      if (!reset && req_if.valid && req_if.ready) begin
         ledger.note_event(op_type'(req_if.op), {req_if.dram_reading, req_if.uncore_reading,
                                                 req_if.core_reading, req_if.pkg_reading});
      end
   end

   initial begin
      int unsigned mode;
      int unsigned left;
      int unsigned tick;
      rsp_if.ready <= 1'b0;
      mode = 0;
      left = 0;
      tick = 0;
      forever begin
         @(posedge clock);
         if (left == 0) begin
            mode = $urandom_range(0, 3);
            left = $urandom_range(32, 256);
         end
         left--;
         tick++;
         case (mode)
            0: rsp_if.ready <= 1'b1;
            1: rsp_if.ready <= 1'($urandom_range(0, 1));
            2: rsp_if.ready <= ($urandom_range(0, 7) == 0);
            default: rsp_if.ready <= ((tick % 5) < 3);
         endcase
      end
   end

   function automatic logic [CTR_W-1:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic ctr_vec_type fill(logic [CTR_W-1:0] value);
      return {CTR_SLOTS{value}};
   endfunction

   function automatic ctr_vec_type rand_readings();
      return {rand64(), rand64(), rand64(), rand64()};
   endfunction

   function void step_readings();
      int i;
      for (i = 0; i < CTR_SLOTS; i++) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: running[i] = running[i] + CTR_W'($urandom_range(0, 4000));
            5, 6: running[i] = running[i] + CTR_W'($urandom);
            7: running[i] = running[i] + rand64();
            8: running[i] = rand64();
            default: running[i] = running[i];
         endcase
      end
   endfunction

   task automatic send_event(op_type op, ctr_vec_type rd);
      int unsigned gap;
      if (burst_left == 0) begin
         if ($urandom_range(0, 3) != 0) begin
            gap = $urandom_range(1, 6);
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_if.valid          <= 1'b1;
      req_if.op             <= op;
      req_if.pkg_reading    <= rd[0];
      req_if.core_reading   <= rd[1];
      req_if.uncore_reading <= rd[2];
      req_if.dram_reading   <= rd[3];
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   task automatic settle_outputs();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (ledger.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_enable(bit value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      ledger.set_enable(value);
   endtask

   task automatic run_random(int count);
      int     n;
      int     r;
      op_type op;
      for (n = 0; n < count; n++) begin
         r = $urandom_range(0, 99);
         if (r < 72) begin
            op = (ledger.phase == PHASE_AWAIT_EXIT) ? OP_GUEST_EXIT : OP_GUEST_ENTRY;
         end else if (r < 80) begin
            op = OP_START;
         end else if (r < 86) begin
            op = OP_END;
         end else begin
            op = op_type'($urandom_range(0, 3));
         end
         step_readings();
         if (r >= 95) begin
            send_event(op, rand_readings());
         end else begin
            send_event(op, running);
         end
      end
   endtask

   initial begin
      #5ms;
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      ledger                = new();
      running               = rand_readings();
      burst_left            = 0;
      reset                 <= 1'b1;
      csr_wr_en             <= 1'b0;
      csr_wr_data           <= 1'b0;
      req_if.valid          <= 1'b0;
      req_if.op             <= OP_GUEST_ENTRY;
      req_if.pkg_reading    <= '0;
      req_if.core_reading   <= '0;
      req_if.uncore_reading <= '0;
      req_if.dram_reading   <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Events arriving before the block is enabled change nothing.
      send_event(OP_GUEST_ENTRY, rand_readings());
      send_event(OP_GUEST_EXIT, rand_readings());
      send_event(OP_START, rand_readings());
      send_event(OP_END, rand_readings());
      settle_outputs();
      write_enable(1'b1);

      send_event(OP_GUEST_EXIT, rand_readings());
      send_event(OP_GUEST_ENTRY, fill('1));
      send_event(OP_GUEST_ENTRY, rand_readings());
      send_event(OP_GUEST_EXIT, fill('0));
      send_event(OP_GUEST_EXIT, rand_readings());
      send_event(OP_GUEST_ENTRY, fill('1));
      send_event(OP_GUEST_EXIT, fill('1));
      send_event(OP_END, rand_readings());
      send_event(OP_GUEST_EXIT, rand_readings());
      send_event(OP_GUEST_ENTRY, rand_readings());
      send_event(OP_GUEST_EXIT, rand_readings());
      send_event(OP_GUEST_ENTRY, rand_readings());
      send_event(OP_START, rand_readings());
      send_event(OP_GUEST_EXIT, rand_readings());
      send_event(OP_GUEST_ENTRY, fill('0));
      send_event(OP_GUEST_EXIT, rand_readings());
      send_event(OP_END, fill('1));
      send_event(OP_GUEST_ENTRY, fill(64'h5555_5555_5555_5555));
      send_event(OP_GUEST_EXIT, fill(64'haaaa_aaaa_aaaa_aaaa));
      settle_outputs();

      // Disabling must freeze the totals reached so far.
      write_enable(1'b0);
      send_event(OP_GUEST_ENTRY, rand_readings());
      send_event(OP_GUEST_EXIT, rand_readings());
      send_event(OP_START, rand_readings());
      settle_outputs();

      write_enable(1'b1);
      run_random(500);
      settle_outputs();
      write_enable(1'b0);
      run_random(40);
      settle_outputs();
      write_enable(1'b1);
      run_random(500);
      settle_outputs();
      write_enable(1'b1);
      run_random(450);
      settle_outputs();

      $display("Covered %0d events, %0d of them ignored while disabled.",
               ledger.events_seen, ledger.ignored_events);
      $display("Checked %0d result transactions, %0d of them with a phase error.",
               ledger.results_seen, ledger.phase_errors);
      if (ledger.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
